>>> hdl/assert_macros.svh
// Assertion macros shared by the table aging block.
// Uses clk and rst_n of the module that includes this file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every rising clock edge outside reset.
`define MLTA_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define MLTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MLTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mlta_pkg.sv
// Package for the MAC learning table: entry layout, codes, controller types, CRC step.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package mlta_pkg;

  // Field widths
  localparam int MAC_W    = 48;
  localparam int PORT_W   = 8;
  localparam int BRIDGE_W = 12;
  localparam int KEY_W    = 32;
  localparam int AGE_W    = 16;
  localparam int KIND_W   = 2;
  localparam int EXP_W    = 7;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam logic [AGE_W-1:0] AGING_DEFAULT = AGE_W'(60 * 5);
  localparam logic [EXP_W-1:0] EXP_MAX = '1;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LEARN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

  // CRC-32, reflected, one byte per step
  localparam logic [KEY_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [KEY_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam int CRC_BYTES = MAC_W / 8;

  // One table slot as stored in the memory
  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [MAC_W-1:0]    mac;
    logic [PORT_W-1:0]   port;
    logic [BRIDGE_W-1:0] bridge;
    logic [AGE_W-1:0]    ttl;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // What the result register is loaded with
  typedef enum logic [2:0] {
    RES_ZERO,
    RES_HIT,
    RES_LEARNED,
    RES_FULL,
    RES_TICK
  } res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CRC,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH,
    ST_DONE
  } ctl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // take in the item, restart hash and scan
    logic crc_step;   // hash one address byte
    logic clear_wr;   // write an empty slot at the sweep address
    logic scan_rd;    // read the slot at the sweep address
    logic scan_eval;  // evaluate the slot read in the previous cycle
    logic age_en;     // the scan is a tick: age live slots
    logic learn_wr;   // write the new slot into the free slot
    logic load_out;   // load the result register
    res_t res_sel;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic crc_last;
    logic addr_last;
    logic match;
    logic free_found;
  } dp_sts_t;

  function automatic logic [KEY_W-1:0] crc_byte(input logic [KEY_W-1:0] crc_in,
                                                input logic [7:0] data);
    logic [KEY_W-1:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hdl/mac_learning_table_aging.sv
// Top level of the MAC learning table with aging: stream ports, register port, and the
// controller, datapath and table memory below. Depends on mlta_pkg, mlta_ctrl, mlta_datapath.
`timescale 1ns / 1ps

// Bridge forwarding table of TABLE_ENTRIES slots keyed by the reflected IEEE CRC-32 of the
// MAC address. Items are taken one at a time. After reset the table is swept empty, one slot
// per cycle, and in_tready stays low until the sweep ends. A learn or lookup first hashes the
// address a byte at a time, then the single table memory is read one slot per cycle until
// the key is found or every slot was seen. A tick reads one slot per cycle and writes back
// each live slot aged. An item of unused kind gives an all-zero result. The result waits in
// an output register, and the next item is taken while it waits. Register 0 at byte address
// 0 holds the time-to-live of new entries in ticks; write it only while no item is in work.

module mac_learning_table_aging #(
  parameter int TABLE_ENTRIES = mlta_pkg::DEF_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,     // mac_address[47:0], port_index[55:48], bridge_id[67:56]
  input  logic [1:0]  in_tuser,     // kind[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,    // found_port[7:0], found_bridge[19:8], found_mac[67:20],
                                    // expired_count[74:68]
  output logic [2:0]  out_tuser,    // hit[0], learned[1], table_full[2]
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mlta_pkg::*;

  localparam logic REG_AGING = 1'b0;

  dp_cmd_t             cmd;
  dp_sts_t             sts;
  logic [AGE_W-1:0]    aging_r;
  logic                hit, learned, table_full;
  logic [PORT_W-1:0]   found_port;
  logic [BRIDGE_W-1:0] found_bridge;
  logic [MAC_W-1:0]    found_mac;
  logic [EXP_W-1:0]    expired_count;
  logic                cfg_wr;

  // Register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aging_r <= AGING_DEFAULT;
    end else if (cfg_wr && (cfg_paddr[2] == REG_AGING)) begin
      aging_r <= cfg_pwdata[AGE_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_AGING) ? {16'd0, aging_r} : 32'd0;

  mlta_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  mlta_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mac        (in_tdata[47:0]),
    .in_port       (in_tdata[55:48]),
    .in_bridge     (in_tdata[67:56]),
    .aging         (aging_r),
    .hit           (hit),
    .learned       (learned),
    .table_full    (table_full),
    .found_port    (found_port),
    .found_bridge  (found_bridge),
    .found_mac     (found_mac),
    .expired_count (expired_count)
  );

  // Result packing
  assign out_tdata = {5'd0, expired_count, found_mac, found_bridge, found_port};
  assign out_tuser = {table_full, learned, hit};

endmodule

>>> hdl/mlta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on mlta_pkg for default sizes only.
`timescale 1ns / 1ps

module mlta_ram #(
  parameter int WIDTH = mlta_pkg::ENTRY_W,
  parameter int DEPTH = mlta_pkg::DEF_TABLE_ENTRIES,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> hdl/mlta_datapath.sv
// Datapath of the MAC learning table: item registers, byte-serial CRC, slot scan,
// aging write-back, result register. Depends on mlta_pkg, mlta_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlta_datapath #(
  parameter int TABLE_ENTRIES = mlta_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mlta_pkg::dp_cmd_t             cmd,
  output mlta_pkg::dp_sts_t             sts,
  input  logic [mlta_pkg::MAC_W-1:0]    in_mac,
  input  logic [mlta_pkg::PORT_W-1:0]   in_port,
  input  logic [mlta_pkg::BRIDGE_W-1:0] in_bridge,
  input  logic [mlta_pkg::AGE_W-1:0]    aging,
  output logic                          hit,
  output logic                          learned,
  output logic                          table_full,
  output logic [mlta_pkg::PORT_W-1:0]   found_port,
  output logic [mlta_pkg::BRIDGE_W-1:0] found_bridge,
  output logic [mlta_pkg::MAC_W-1:0]    found_mac,
  output logic [mlta_pkg::EXP_W-1:0]    expired_count
);
  import mlta_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Item and hash state
  logic [MAC_W-1:0]    mac_r;
  logic [PORT_W-1:0]   port_r;
  logic [BRIDGE_W-1:0] bridge_r;
  logic [MAC_W-1:0]    sh_r;
  logic [KEY_W-1:0]    crc_r;
  logic [2:0]          byte_cnt_r;

  // Scan state
  logic [IDX_W-1:0]    addr_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                free_found_r;
  logic [IDX_W-1:0]    free_idx_r;
  logic [EXP_W-1:0]    expired_r;

  // Matched slot
  logic [MAC_W-1:0]    hit_mac_r;
  logic [PORT_W-1:0]   hit_port_r;
  logic [BRIDGE_W-1:0] hit_bridge_r;

  // Result register
  logic                out_hit_r, out_learned_r, out_full_r;
  logic [PORT_W-1:0]   out_port_r;
  logic [BRIDGE_W-1:0] out_bridge_r;
  logic [MAC_W-1:0]    out_mac_r;
  logic [EXP_W-1:0]    out_exp_r;

  logic                out_hit_nxt, out_learned_nxt, out_full_nxt;
  logic [PORT_W-1:0]   out_port_nxt;
  logic [BRIDGE_W-1:0] out_bridge_nxt;
  logic [MAC_W-1:0]    out_mac_nxt;
  logic [EXP_W-1:0]    out_exp_nxt;

  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]    ram_waddr;
  logic                ram_we;

  entry_t              ent;
  entry_t              new_ent;
  entry_t              aged_ent;
  logic [KEY_W-1:0]    key_w;
  logic                addr_last;
  logic                eval_live;
  logic                match;
  logic                free_take;
  logic                ttl_out;
  logic                age_wr;

  // Slot evaluation
  assign ent       = entry_t'(ram_rdata);
  assign key_w     = ~crc_r;
  assign addr_last = (addr_r == IDX_W'(TABLE_ENTRIES - 1));
  assign eval_live = cmd.scan_eval && rd_vld_r;
  assign match     = eval_live && !cmd.age_en && ent.valid && (ent.key == key_w);
  assign free_take = eval_live && !ent.valid && !free_found_r;
  assign ttl_out   = (ent.ttl <= AGE_W'(1));
  assign age_wr    = eval_live && cmd.age_en && ent.valid;

  assign sts.crc_last   = (byte_cnt_r == 3'(CRC_BYTES - 1));
  assign sts.addr_last  = addr_last;
  assign sts.match      = match;
  assign sts.free_found = free_found_r;

  // Slot images for the write port
  always_comb begin
    new_ent.valid  = 1'b1;
    new_ent.key    = key_w;
    new_ent.mac    = mac_r;
    new_ent.port   = port_r;
    new_ent.bridge = bridge_r;
    new_ent.ttl    = aging;

    aged_ent = ent;
    if (ttl_out) begin
      aged_ent.valid = 1'b0;
      aged_ent.ttl   = '0;
    end else begin
      aged_ent.ttl = ent.ttl - AGE_W'(1);
    end
  end

  // Write port select
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    if (cmd.clear_wr) begin
      ram_we = 1'b1;
    end else if (cmd.learn_wr) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx_r;
      ram_wdata = new_ent;
    end else if (age_wr) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx_r;
      ram_wdata = aged_ent;
    end
  end

  mlta_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan_rd),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // Control registers of the scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r       <= '0;
      rd_vld_r     <= 1'b0;
      free_found_r <= 1'b0;
      expired_r    <= '0;
      byte_cnt_r   <= '0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.capture) begin
        addr_r       <= '0;
        free_found_r <= 1'b0;
        expired_r    <= '0;
        byte_cnt_r   <= '0;
      end else begin
        if (cmd.clear_wr || cmd.scan_rd) begin
          addr_r <= addr_last ? '0 : addr_r + IDX_W'(1);
        end
        if (cmd.crc_step) begin
          byte_cnt_r <= byte_cnt_r + 3'd1;
        end
        if (free_take) begin
          free_found_r <= 1'b1;
        end
        // freed slots, saturating
        if (age_wr && ttl_out && (expired_r != EXP_MAX)) begin
          expired_r <= expired_r + EXP_W'(1);
        end
      end
    end
  end

  // Item, hash and slot payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mac_r    <= in_mac;
      port_r   <= in_port;
      bridge_r <= in_bridge;
      sh_r     <= in_mac;
      crc_r    <= CRC_INIT;
    end else if (cmd.crc_step) begin
      crc_r <= crc_byte(crc_r, sh_r[MAC_W-1 -: 8]);
      sh_r  <= {sh_r[MAC_W-9:0], 8'd0};
    end
    if (cmd.scan_rd) begin
      rd_idx_r <= addr_r;
    end
    if (free_take) begin
      free_idx_r <= rd_idx_r;
    end
    if (match) begin
      hit_mac_r    <= ent.mac;
      hit_port_r   <= ent.port;
      hit_bridge_r <= ent.bridge;
    end
  end

  // Result selection
  always_comb begin
    out_hit_nxt     = 1'b0;
    out_learned_nxt = 1'b0;
    out_full_nxt    = 1'b0;
    out_port_nxt    = '0;
    out_bridge_nxt  = '0;
    out_mac_nxt     = '0;
    out_exp_nxt     = '0;
    case (cmd.res_sel)
      RES_HIT: begin
        out_hit_nxt    = 1'b1;
        out_port_nxt   = hit_port_r;
        out_bridge_nxt = hit_bridge_r;
        out_mac_nxt    = hit_mac_r;
      end
      RES_LEARNED: out_learned_nxt = 1'b1;
      RES_FULL:    out_full_nxt    = 1'b1;
      RES_TICK:    out_exp_nxt     = expired_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r     <= out_hit_nxt;
      out_learned_r <= out_learned_nxt;
      out_full_r    <= out_full_nxt;
      out_port_r    <= out_port_nxt;
      out_bridge_r  <= out_bridge_nxt;
      out_mac_r     <= out_mac_nxt;
      out_exp_r     <= out_exp_nxt;
    end
  end

  assign hit           = out_hit_r;
  assign learned       = out_learned_r;
  assign table_full    = out_full_r;
  assign found_port    = out_port_r;
  assign found_bridge  = out_bridge_r;
  assign found_mac     = out_mac_r;
  assign expired_count = out_exp_r;

  // At most one writer of the table in any cycle
  `MLTA_ASSERT_HOLD(a_wr_excl, $onehot0({cmd.clear_wr, cmd.learn_wr, age_wr}), "two table writers at once")

endmodule

>>> hdl/mlta_ctrl.sv
// Controller of the MAC learning table: clearing sweep, hash, scan and result sequencing,
// output valid. Depends on mlta_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlta_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mlta_pkg::KIND_W-1:0] in_kind,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output mlta_pkg::dp_cmd_t           cmd,
  input  mlta_pkg::dp_sts_t           sts
);
  import mlta_pkg::*;

  ctl_state_t         state_r, state_nxt;
  res_t               res_r, res_nxt;
  logic [KIND_W-1:0]  kind_r, kind_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               is_tick;
  logic               out_free;

  assign is_tick  = (kind_r == KIND_TICK);
  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    kind_nxt  = kind_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.addr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = in_kind;
          unique case (in_kind) inside
            KIND_LEARN, KIND_LOOKUP: state_nxt = ST_CRC;
            KIND_TICK:               state_nxt = ST_SCAN;
            default: begin
              state_nxt = ST_DONE;
              res_nxt   = RES_ZERO;
            end
          endcase
        end
      end
      ST_CRC: begin
        if (sts.crc_last) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.match && !is_tick) begin
          state_nxt = ST_DONE;
          res_nxt   = RES_HIT;
        end else if (sts.addr_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.match && !is_tick) begin
          state_nxt = ST_DONE;
          res_nxt   = RES_HIT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_nxt = ST_DONE;
        if (is_tick) begin
          res_nxt = RES_TICK;
        end else if (kind_r == KIND_LOOKUP) begin
          res_nxt = RES_ZERO;
        end else if (sts.free_found) begin
          res_nxt = RES_LEARNED;
        end else begin
          res_nxt = RES_FULL;
        end
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clear_wr = 1'b1;
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_CRC: cmd.crc_step = 1'b1;
      ST_SCAN: begin
        cmd.scan_rd   = 1'b1;
        cmd.scan_eval = 1'b1;
        cmd.age_en    = is_tick;
      end
      ST_DRAIN: begin
        cmd.scan_eval = 1'b1;
        cmd.age_en    = is_tick;
      end
      ST_FINISH: cmd.learn_wr = (kind_r == KIND_LEARN) && sts.free_found;
      ST_DONE: begin
        cmd.load_out = out_free;
        cmd.res_sel  = res_r;
      end
      default: ;
    endcase
  end

  // Output valid
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      res_r       <= RES_ZERO;
      kind_r      <= KIND_LEARN;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      kind_r      <= kind_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `MLTA_ASSERT_IMP(a_load_free, cmd.load_out, (!out_valid_r || out_tready), "result overwritten before transfer")
  `MLTA_ASSERT_NXT(a_one_item, (in_tvalid && in_tready), !in_tready, "second item taken while one is in work")
  `MLTA_ASSERT_IMP(a_learn_slot, cmd.learn_wr, (sts.free_found && kind_r == KIND_LEARN), "slot written without a free slot")

endmodule

>>> bench/mlta_fdb_checker.sv
// Checker for mac_learning_table_aging: watches the item, result and register channels,
// keeps its own copy of the forwarding table and compares every result. Depends on mlta_pkg.
`timescale 1ns / 1ps

module mlta_fdb_checker #(
  parameter int              TABLE_ENTRIES  = mlta_pkg::DEF_TABLE_ENTRIES,
  parameter logic [2:0]      AGING_REG_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,     // mac_address[47:0], port_index[55:48], bridge_id[67:56]
  input  logic [1:0]  in_tuser,     // kind[1:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,    // found_port[7:0], found_bridge[19:8], found_mac[67:20],
                                    // expired_count[74:68]
  input  logic [2:0]  out_tuser,    // hit[0], learned[1], table_full[2]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          replies_owed
);
  import mlta_pkg::*;

  localparam logic [KEY_W-1:0] HASH_POLY = 32'hEDB8_8320;

  typedef struct packed {
    logic                hit;
    logic                learned;
    logic                table_full;
    logic [PORT_W-1:0]   port;
    logic [BRIDGE_W-1:0] bridge;
    logic [MAC_W-1:0]    mac;
    logic [EXP_W-1:0]    expired;
  } fdb_reply_t;

  // Shadow copy of the forwarding table and the aging register
  logic                slot_live   [TABLE_ENTRIES];
  logic [KEY_W-1:0]    slot_key    [TABLE_ENTRIES];
  logic [MAC_W-1:0]    slot_mac    [TABLE_ENTRIES];
  logic [PORT_W-1:0]   slot_port   [TABLE_ENTRIES];
  logic [BRIDGE_W-1:0] slot_bridge [TABLE_ENTRIES];
  logic [AGE_W-1:0]    slot_ttl    [TABLE_ENTRIES];
  logic [AGE_W-1:0]    new_ttl;

  fdb_reply_t fdb_reply_q[$];

  initial begin
    fail_count   = 0;
    replies_owed = 0;
  end

  // Reflected CRC-32 over the six address bytes, byte 0 (top bits) first, bit by bit
  function automatic logic [KEY_W-1:0] mac_hash(input logic [MAC_W-1:0] mac);
    logic [KEY_W-1:0] c;
    logic             fb;
    c = '1;
    for (int b = CRC_BYTES - 1; b >= 0; b--) begin
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ mac[8*b + k];
        c  = c >> 1;
        if (fb) c = c ^ HASH_POLY;
      end
    end
    return ~c;
  endfunction

  function automatic fdb_reply_t slot_reply(input int s);
    fdb_reply_t r;
    r        = '0;
    r.hit    = 1'b1;
    r.port   = slot_port[s];
    r.bridge = slot_bridge[s];
    r.mac    = slot_mac[s];
    return r;
  endfunction

  // Apply one item to the shadow table and return the result it should produce
  function automatic fdb_reply_t fdb_process_item(input logic [KIND_W-1:0]   kind,
                                                  input logic [MAC_W-1:0]    mac,
                                                  input logic [PORT_W-1:0]   port,
                                                  input logic [BRIDGE_W-1:0] bridge);
    fdb_reply_t       r;
    logic [KEY_W-1:0] key;
    int               match_slot;
    int               free_slot;
    r          = '0;
    key        = mac_hash(mac);
    match_slot = -1;
    free_slot  = -1;
    // walk downward so the lowest-numbered slot wins
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_live[i] && slot_key[i] == key) match_slot = i;
      if (!slot_live[i]) free_slot = i;
    end
    case (kind)
      KIND_LEARN: begin
        if (match_slot >= 0) begin
          r = slot_reply(match_slot);
        end else if (free_slot < 0) begin
          r.table_full = 1'b1;
        end else begin
          slot_live[free_slot]   = 1'b1;
          slot_key[free_slot]    = key;
          slot_mac[free_slot]    = mac;
          slot_port[free_slot]   = port;
          slot_bridge[free_slot] = bridge;
          slot_ttl[free_slot]    = new_ttl;
          r.learned              = 1'b1;
        end
      end
      KIND_LOOKUP: begin
        if (match_slot >= 0) r = slot_reply(match_slot);
      end
      KIND_TICK: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (slot_live[i]) begin
            if (slot_ttl[i] <= 1) begin
              slot_live[i] = 1'b0;
              if (r.expired != EXP_MAX) r.expired = r.expired + 1'b1;
            end else begin
              slot_ttl[i] = slot_ttl[i] - 1'b1;
            end
          end
        end
      end
      default: ;  // spare kind: nothing changes, all-zero result
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Sample all channels at the rising edge
  always @(posedge clk) begin
    fdb_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_live[i] = 1'b0;
      new_ttl = AGING_DEFAULT;
      fdb_reply_q.delete();
    end else begin
      // result transfer: compare with the oldest pending reply
      if (out_tvalid && out_tready) begin
        if (fdb_reply_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got tdata 0x%0h tuser 0x%0h",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = fdb_reply_q.pop_front();
          check_field("hit",           want.hit,        out_tuser[0]);
          check_field("learned",       want.learned,    out_tuser[1]);
          check_field("table_full",    want.table_full, out_tuser[2]);
          check_field("found_port",    want.port,       out_tdata[7:0]);
          check_field("found_bridge",  want.bridge,     out_tdata[19:8]);
          check_field("found_mac",     want.mac,        out_tdata[67:20]);
          check_field("expired_count", want.expired,    out_tdata[74:68]);
        end
      end
      // item transfer
      if (in_tvalid && in_tready)
        fdb_reply_q.push_back(fdb_process_item(in_tuser, in_tdata[47:0], in_tdata[55:48],
                                               in_tdata[67:56]));
      // register port
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == AGING_REG_ADDR) begin
        if (cfg_pwrite)
          new_ttl = cfg_pwdata[AGE_W-1:0];
        else
          check_field("aging register read", {16'd0, new_ttl}, cfg_prdata);
      end
    end
    replies_owed = fdb_reply_q.size();
  end

endmodule

>>> bench/tb.sv
// Top of the mac_learning_table_aging bench: clock, reset, item and register stimulus,
// result-side stalls and the verdict. Depends on mlta_pkg, mlta_fdb_checker and the block.
`timescale 1ns / 1ps

module tb;
  import mlta_pkg::*;

  localparam int              TABLE_ENTRIES = DEF_TABLE_ENTRIES;
  localparam logic [2:0]      AGING_ADDR    = 3'd0;
  localparam logic [2:0]      SPARE_ADDR    = 3'd4;   // no register here, writes ignored
  localparam logic [KIND_W-1:0] KIND_SPARE  = 2'd3;
  localparam int              MAC_POOL      = 24;
  localparam int              CYCLE_LIMIT   = 1_000_000;
  localparam int              TAIL_CYCLES   = TABLE_ENTRIES + 40;
  localparam int              LONG_HOLD     = 1000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;     // mac_address[47:0], port_index[55:48], bridge_id[67:56]
  logic [1:0]  in_tuser;     // kind[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;    // found_port[7:0], found_bridge[19:8], found_mac[67:20],
                             // expired_count[74:68]
  logic [2:0]  out_tuser;    // hit[0], learned[1], table_full[2]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int replies_owed;
  int replies_taken;
  int cycle_count;
  int ticks_sent;
  bit tx_steady;
  bit rx_steady;
  bit long_hold_done;

  logic [MAC_W-1:0] mac_pool [MAC_POOL];

  mac_learning_table_aging #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  mlta_fdb_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .AGING_REG_ADDR(AGING_ADDR)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready),
    .fail_count(fail_count), .replies_owed(replies_owed)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog and result transfer count
  initial begin
    cycle_count   = 0;
    replies_taken = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (out_tvalid && out_tready) replies_taken++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mac_learning_table_aging regression: fail");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic [MAC_W-1:0] pick_mac();
    if ($urandom_range(3) == 0) return MAC_W'({$urandom(), $urandom()});
    return mac_pool[$urandom_range(MAC_POOL - 1)];
  endfunction

  // Result side: random stalls, quiet windows, and one long hold-off
  initial begin : result_side
    int stall_left;
    int hold_cycles;
    int rx_cycle;
    out_tready     = 1'b0;
    stall_left     = 0;
    rx_cycle       = 0;
    rx_steady      = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_steady = ($urandom_range(3) == 0);
      if (!long_hold_done && replies_taken >= 60) begin
        long_hold_done = 1'b1;
        out_tready     = 1'b0;
        hold_cycles    = 0;
        while (hold_cycles < LONG_HOLD) begin
          @(negedge clk);
          hold_cycles++;
        end
      end
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!rx_steady && $urandom_range(99) < 25) stall_left = pick_gap();
      end
    end
  end

  // One item transfer; called and returns at a falling edge, valid stays up afterwards
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [MAC_W-1:0] mac,
                           input logic [PORT_W-1:0] port, input logic [BRIDGE_W-1:0] bridge);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {4'd0, bridge, port, mac};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (kind == KIND_TICK) ticks_sent++;
  endtask

  // Stop offering items until every result is back
  task automatic settle();
    in_tvalid = 1'b0;
    while (replies_owed != 0) @(negedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    cfg_psel    = 1'b1;
    cfg_pwrite  = wr;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Write the aging register with junk in the unused upper bits, then read it back
  task automatic set_aging(input logic [AGE_W-1:0] ticks);
    reg_access(1'b1, AGING_ADDR, {16'($urandom()), ticks});
    reg_access(1'b0, AGING_ADDR, 32'd0);
  endtask

  task automatic run_mix(input int count, input int learn_w, input int lookup_w,
                         input int tick_w);
    int               pick;
    logic [KIND_W-1:0] kind;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) tx_steady = ($urandom_range(4) == 0);
      pick = $urandom_range(99);
      if (pick < learn_w)                          kind = KIND_LEARN;
      else if (pick < learn_w + lookup_w)          kind = KIND_LOOKUP;
      else if (pick < learn_w + lookup_w + tick_w) kind = KIND_TICK;
      else                                         kind = KIND_SPARE;
      send_item(kind, pick_mac(), PORT_W'($urandom_range(255)),
                BRIDGE_W'($urandom_range(4095)));
    end
  endtask

  // A phase: new aging value, fresh address pool, random traffic, then drain
  task automatic run_phase(input logic [AGE_W-1:0] ticks, input int count, input int learn_w,
                           input int lookup_w, input int tick_w);
    set_aging(ticks);
    for (int i = 0; i < MAC_POOL; i++) mac_pool[i] = MAC_W'({$urandom(), $urandom()});
    run_mix(count, learn_w, lookup_w, tick_w);
    settle();
  endtask

  // Stimulus
  initial begin : stimulus
    int drain;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    ticks_sent  = 0;
    tx_steady   = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed, reset aging value: miss on empty table, extremes, known key, spare kind, tick
    reg_access(1'b0, AGING_ADDR, 32'd0);
    send_item(KIND_LOOKUP, 48'd0, 8'd0, 12'd0);
    send_item(KIND_LEARN,  48'd0, 8'd0, 12'd0);
    send_item(KIND_LEARN,  48'hFFFF_FFFF_FFFF, 8'hFF, 12'hFFF);
    send_item(KIND_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'd0, 12'd0);
    send_item(KIND_LOOKUP, 48'd0, 8'hFF, 12'hFFF);
    send_item(KIND_LEARN,  48'hFFFF_FFFF_FFFF, 8'h01, 12'h001);  // known key, no refresh
    send_item(KIND_LOOKUP, 48'hFFFF_FFFF_FFFF, 8'd0, 12'd0);
    send_item(KIND_SPARE,  48'hA5A5_5A5A_C3C3, 8'hFF, 12'hFFF);
    send_item(KIND_TICK,   48'd0, 8'd0, 12'd0);
    send_item(KIND_LEARN,  48'h0123_4567_89AB, 8'hA5, 12'h5A3);
    settle();

    // Zero time-to-live: freed by the next tick
    set_aging(16'd0);
    send_item(KIND_LEARN,  48'h8000_0000_0001, 8'h80, 12'h800);
    send_item(KIND_LOOKUP, 48'h8000_0000_0001, 8'd0, 12'd0);
    send_item(KIND_TICK,   48'd0, 8'd0, 12'd0);
    send_item(KIND_LOOKUP, 48'h8000_0000_0001, 8'd0, 12'd0);
    settle();

    // Write to an address with no register, then minimum aging
    reg_access(1'b1, SPARE_ADDR, 32'h0000_0005);
    reg_access(1'b0, AGING_ADDR, 32'd0);
    set_aging(16'd1);
    send_item(KIND_LEARN,  48'h0000_0000_FF00, 8'h3C, 12'h7FF);
    send_item(KIND_TICK,   48'd0, 8'd0, 12'd0);
    send_item(KIND_LOOKUP, 48'h0000_0000_FF00, 8'd0, 12'd0);
    send_item(KIND_SPARE,  48'hFFFF_FFFF_FFFF, 8'd0, 12'd0);
    settle();

    // Random traffic over several aging values; long result hold-off falls in the first
    run_phase(16'd6,  300, 40, 30, 28);
    run_phase(16'd1,  120, 50, 30, 18);
    run_phase(16'd40, 200, 55, 25, 18);
    run_phase(16'd3,  100, 40, 35, 23);

    // Age out everything, including the entries learned at the reset value
    drain = 305 - ticks_sent;
    if (drain < 41) drain = 41;
    for (int n = 0; n < drain; n++) send_item(KIND_TICK, pick_mac(), 8'd0, 12'd0);
    settle();

    // Fill past capacity at aging 1, then one tick frees every slot at once
    set_aging(16'd1);
    for (int n = 0; n < TABLE_ENTRIES + 6; n++)
      send_item(KIND_LEARN, MAC_W'({$urandom(), $urandom()}), PORT_W'($urandom_range(255)),
                BRIDGE_W'($urandom_range(4095)));
    send_item(KIND_TICK, 48'd0, 8'd0, 12'd0);
    send_item(KIND_TICK, 48'd0, 8'd0, 12'd0);
    settle();

    // Maximum aging
    run_phase(16'hFFFF, 150, 40, 40, 18);

    in_tvalid = 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && replies_owed == 0)
      $display("mac_learning_table_aging regression: pass");
    else
      $display("mac_learning_table_aging regression: fail");
    $finish;
  end

endmodule
